// File: rtl/sorted_key_shift_union_top_defines.svh
// assertion macros shared by the sorted key shift union checker
// no dependencies; include by bare file name
`ifndef SORTED_KEY_SHIFT_UNION_TOP_DEFINES_SVH
`define SORTED_KEY_SHIFT_UNION_TOP_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define SKUS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while in reset
`define SKUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also runs across reset
`define SKUS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/skus_pkg.sv
// shared types and constants for the sorted key shift union block
// no dependencies
package skus_pkg;

  localparam int KEY_W = 32;

  // one classified input item as handed from the front to the back
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] shifted;
    logic             push_ok;
    logic             last;
  } skus_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FLUSH
  } skus_state_t;

endpackage

// File: rtl/skus_front.sv
// front end: accepts input keys, holds the offset register, forms the shifted copy
// depends on skus_pkg
module skus_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [skus_pkg::KEY_W-1:0] in_tdata,  // [31:0] in_key
  input  logic                     in_tlast,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [skus_pkg::KEY_W-1:0] cfg_data,  // [31:0] key_offset
  input  logic                     cmd_ready,
  output logic                     cmd_push,
  output skus_pkg::skus_cmd_t      cmd_data
);
  import skus_pkg::*;

  logic [KEY_W-1:0] key_offset_r;
  logic [KEY_W:0]   shifted_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_offset_r <= KEY_W'(1);
    end else if (cfg_valid) begin
      key_offset_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_tready = cmd_ready;
  assign cmd_push  = in_tvalid & cmd_ready;

  // carry out of the sum means the copy would leave the key range
  assign shifted_sum = {1'b0, in_tdata} + {1'b0, key_offset_r};

  always_comb begin
    cmd_data.key     = in_tdata;
    cmd_data.shifted = shifted_sum[KEY_W-1:0];
    cmd_data.push_ok = (key_offset_r != '0) && !shifted_sum[KEY_W];
    cmd_data.last    = in_tlast;
  end

endmodule

// File: rtl/skus_cmd_fifo.sv
// two-entry queue of classified items between front and back
// depends on skus_pkg
module skus_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  skus_pkg::skus_cmd_t wr_data,
  output logic                wr_ready,
  input  logic                rd_en,
  output logic                rd_valid,
  output skus_pkg::skus_cmd_t rd_data
);
  import skus_pkg::*;

  skus_cmd_t  entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] level_r;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (level_r != 2'd2);
  assign rd_valid = (level_r != 2'd0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign do_wr    = wr_en & wr_ready;
  assign do_rd    = rd_en & rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      level_r <= level_r + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

// File: rtl/skus_back.sv
// back end: pending queue of shifted copies, merge sequencer and output register
// depends on skus_pkg
module skus_back #(
  parameter int PENDING_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  skus_pkg::skus_cmd_t        cmd,
  output logic                       cmd_take,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [skus_pkg::KEY_W-1:0] out_tdata,  // [31:0] out_key
  output logic                       out_tlast,
  output logic                       out_tuser   // [0] queue_overflow
);
  import skus_pkg::*;

  localparam int PTR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PENDING_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(PENDING_DEPTH - 1);

  skus_state_t state_r, state_nxt;
  skus_cmd_t   cmd_r;
  logic        seen_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [KEY_W-1:0] head_val_r;
  logic [KEY_W-1:0] pend_mem [PENDING_DEPTH];

  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  logic             out_last_r;
  logic             out_ovf_r;

  logic             out_free;
  logic             q_nonempty;
  logic             head_lt;
  logic             head_eq;
  logic [CNT_W-1:0] room_cnt;
  logic             push_fit;
  logic [CNT_W-1:0] count_after;

  logic             pop;
  logic             push;
  logic             emit;
  logic [KEY_W-1:0] emit_key;
  logic             emit_last;
  logic             clear_list;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  assign out_free   = !out_valid_r || out_tready;
  assign q_nonempty = (count_r != '0);
  assign head_lt    = q_nonempty && (head_val_r < cmd_r.key);
  assign head_eq    = q_nonempty && (head_val_r == cmd_r.key);
  assign room_cnt   = count_r - CNT_W'(head_eq);
  assign push_fit   = cmd_r.push_ok && (room_cnt < DEPTH_CNT);
  assign count_after = room_cnt + CNT_W'(push_fit);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (out_free && !head_lt) begin
          state_nxt = (cmd_r.last && count_after != '0) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free && count_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    cmd_take   = 1'b0;
    pop        = 1'b0;
    push       = 1'b0;
    emit       = 1'b0;
    emit_key   = head_val_r;
    emit_last  = 1'b0;
    clear_list = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd_take = cmd_valid;
      end
      ST_STEP: begin
        if (out_free) begin
          emit = 1'b1;
          if (head_lt) begin
            pop = 1'b1;
          end else begin
            // an equal head is dropped, then the key goes out and its copy is queued if allowed and it fits
            pop        = head_eq;
            push       = push_fit;
            emit_key   = cmd_r.key;
            emit_last  = cmd_r.last && (count_after == '0);
            clear_list = emit_last;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit       = 1'b1;
          pop        = 1'b1;
          emit_last  = (count_r == CNT_W'(1));
          clear_list = emit_last;
        end
      end
      default: begin
        cmd_take = 1'b0;
      end
    endcase
  end

  assign head_nxt  = pop  ? ptr_inc(head_r) : head_r;
  assign tail_nxt  = push ? ptr_inc(tail_r) : tail_r;
  assign count_nxt = count_r - CNT_W'(pop) + CNT_W'(push);

  // pending queue storage; the read port follows the head, bypassing a same-slot write
  always_ff @(posedge clk) begin
    if (push) begin
      pend_mem[tail_r] <= cmd_r.shifted;
    end
    if (push && tail_r == head_nxt) begin
      head_val_r <= cmd_r.shifted;
    end else begin
      head_val_r <= pend_mem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_r <= cmd;
    end
    if (emit) begin
      out_key_r  <= emit_key;
      out_last_r <= emit_last;
      out_ovf_r  <= seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= 1'b0;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      // a full queue whose head lies above the key sees no pops, so the push is lost
      if (cmd_take) begin
        seen_r <= seen_r | (cmd.push_ok && count_r == DEPTH_CNT && head_val_r > cmd.key);
      end else if (clear_list) begin
        seen_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_key_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

// File: rtl/sorted_key_shift_union_top.sv
// top level of the sorted key shift union block
// depends on skus_pkg, skus_front, skus_cmd_fifo, skus_back
//
// in_*  : ascending unique keys, tlast ends a list
// out_* : ascending union of the keys and the keys plus key_offset, tlast on the
//         final result of a list, tuser set once a shifted copy was lost to a full queue
// cfg_* : writes key_offset (reset value 1, zero disables copies); always ready,
//         write only while no list is in flight
// the front puts each key in a two-entry queue, so up to two keys wait while the back
// works. the back loads an item in its idle state, then sends the queued copies below
// the key and then the key; a final key then flushes the copies left. no new item is
// loaded until the last is done. a key passes the front queue, the item register and
// the output register. the merge sequencer and its single pending-queue read port set
// the pace. a stalled out_tready holds the result register and the sequencer; the
// input keeps flowing until the front queue fills. reset empties all queues, clears
// the overflow flag and drops out_tvalid; no memory clearing pass is needed
module sorted_key_shift_union_top #(
  parameter int PENDING_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [skus_pkg::KEY_W-1:0] in_tdata,   // [31:0] in_key
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [skus_pkg::KEY_W-1:0] out_tdata,  // [31:0] out_key
  output logic                       out_tlast,
  output logic                       out_tuser,  // [0] queue_overflow
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [skus_pkg::KEY_W-1:0] cfg_data    // [31:0] key_offset
);
  import skus_pkg::*;

  skus_cmd_t front_cmd;
  skus_cmd_t back_cmd;
  logic      front_push;
  logic      fifo_ready;
  logic      fifo_valid;
  logic      back_take;

  skus_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_ready (fifo_ready),
    .cmd_push  (front_push),
    .cmd_data  (front_cmd)
  );

  skus_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (front_push),
    .wr_data  (front_cmd),
    .wr_ready (fifo_ready),
    .rd_en    (back_take),
    .rd_valid (fifo_valid),
    .rd_data  (back_cmd)
  );

  skus_back #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (fifo_valid),
    .cmd        (back_cmd),
    .cmd_take   (back_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/skus_checker.sv
// port-level checks for the sorted key shift union block, bound to its top level
// depends on skus_pkg and sorted_key_shift_union_top_defines.svh
`include "sorted_key_shift_union_top_defines.svh"

module skus_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [skus_pkg::KEY_W-1:0] out_tdata,
  input logic                       out_tlast,
  input logic                       out_tuser,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);

  logic out_xfer;
  logic out_stall;
  logic ovf_hold_r;

  assign out_xfer  = out_tvalid & out_tready;
  assign out_stall = out_tvalid & ~out_tready;

  // overflow flag seen within the current list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_hold_r <= 1'b0;
    end else if (out_xfer) begin
      ovf_hold_r <= out_tuser & ~out_tlast;
    end
  end

  `SKUS_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_tvalid, "result valid right after reset")
  `SKUS_ASSERT_NEXT(a_stall_hold, out_stall, out_tvalid && $stable(out_tdata), "result moved")
  `SKUS_ASSERT_NOW(a_ovf_sticky, out_xfer && ovf_hold_r, out_tuser, "overflow flag fell")
  `SKUS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config port not ready")

endmodule

bind sorted_key_shift_union_top skus_checker u_skus_checker (.*);
